@@ sv/hrlc_pkg.sv @@
// Shared phase and status codes, result type and character class functions.
`default_nettype none

package hrlc_pkg;

	// Result status codes.
	localparam logic [1:0] ST_MORE = 2'd0;
	localparam logic [1:0] ST_DONE = 2'd1;
	localparam logic [1:0] ST_ERR  = 2'd2;
	localparam logic [1:0] ST_NSUP = 2'd3;

	// Parser phase codes.
	localparam logic [4:0] PH_METHOD_START = 5'd0;
	localparam logic [4:0] PH_METHOD       = 5'd1;
	localparam logic [4:0] PH_URI_START    = 5'd2;
	localparam logic [4:0] PH_SCHEME       = 5'd3;
	localparam logic [4:0] PH_SLASH1       = 5'd4;
	localparam logic [4:0] PH_SLASH2       = 5'd5;
	localparam logic [4:0] PH_HOST_START   = 5'd6;
	localparam logic [4:0] PH_HOST         = 5'd7;
	localparam logic [4:0] PH_HOST_END     = 5'd8;
	localparam logic [4:0] PH_IP_LITERAL   = 5'd9;
	localparam logic [4:0] PH_PORT         = 5'd10;
	localparam logic [4:0] PH_PATH         = 5'd11;
	localparam logic [4:0] PH_QUERY        = 5'd12;
	localparam logic [4:0] PH_H            = 5'd13;
	localparam logic [4:0] PH_HT           = 5'd14;
	localparam logic [4:0] PH_HTT          = 5'd15;
	localparam logic [4:0] PH_HTTP         = 5'd16;
	localparam logic [4:0] PH_VSLASH       = 5'd17;
	localparam logic [4:0] PH_MAJOR_START  = 5'd18;
	localparam logic [4:0] PH_MAJOR        = 5'd19;
	localparam logic [4:0] PH_MINOR_START  = 5'd20;
	localparam logic [4:0] PH_MINOR        = 5'd21;
	localparam logic [4:0] PH_TRAIL_SP     = 5'd22;
	localparam logic [4:0] PH_LF_EXPECT    = 5'd23;

	// Byte constants.
	localparam logic [7:0] CH_HTAB  = 8'h09;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_SP    = 8'h20;
	localparam logic [7:0] CH_PCT   = 8'h25;
	localparam logic [7:0] CH_DOT   = 8'h2E;
	localparam logic [7:0] CH_SLASH = 8'h2F;
	localparam logic [7:0] CH_COLON = 8'h3A;
	localparam logic [7:0] CH_QUEST = 8'h3F;
	localparam logic [7:0] CH_LBRK  = 8'h5B;
	localparam logic [7:0] CH_H     = 8'h48;
	localparam logic [7:0] CH_P     = 8'h50;
	localparam logic [7:0] CH_T     = 8'h54;

	// One result of the parser step.
	typedef struct packed {
		logic [1:0] status;
		logic [4:0] phase;
	} step_res_t;

	function automatic logic is_alpha(input logic [7:0] c);
		return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A);
	endfunction

	function automatic logic is_digit(input logic [7:0] c);
		return c >= 8'h30 && c <= 8'h39;
	endfunction

	// Token characters: ALPHA DIGIT ! # $ % & ' * + - . ^ _ ` | ~
	function automatic logic is_token(input logic [7:0] c);
		return is_alpha(c) || is_digit(c) || c == 8'h21 || c == 8'h23 || c == 8'h24 ||
			c == 8'h25 || c == 8'h26 || c == 8'h27 || c == 8'h2A || c == 8'h2B ||
			c == 8'h2D || c == 8'h2E || c == 8'h5E || c == 8'h5F || c == 8'h60 ||
			c == 8'h7C || c == 8'h7E;
	endfunction

	// Scheme characters: ALPHA DIGIT + - .
	function automatic logic is_scheme(input logic [7:0] c);
		return is_alpha(c) || is_digit(c) || c == 8'h2B || c == 8'h2D || c == 8'h2E;
	endfunction

	// Unreserved plus sub-delims: ALPHA DIGIT - . _ ~ ! $ & ' ( ) * + , ; =
	function automatic logic is_unres_sub(input logic [7:0] c);
		return is_alpha(c) || is_digit(c) || c == 8'h2D || c == 8'h2E || c == 8'h5F ||
			c == 8'h7E || c == 8'h21 || c == 8'h24 || c == 8'h26 || c == 8'h27 ||
			c == 8'h28 || c == 8'h29 || c == 8'h2A || c == 8'h2B || c == 8'h2C ||
			c == 8'h3B || c == 8'h3D;
	endfunction

	function automatic logic is_host(input logic [7:0] c);
		return is_unres_sub(c) || c == CH_PCT;
	endfunction

	// Path characters add : @ / and %.
	function automatic logic is_path(input logic [7:0] c);
		return is_unres_sub(c) || c == CH_COLON || c == 8'h40 || c == CH_SLASH ||
			c == CH_PCT;
	endfunction

endpackage

`default_nettype wire

@@ sv/hrlc_step.sv @@
// Next-phase and status logic of the request line parser for one byte.
`default_nettype none

module hrlc_step
	import hrlc_pkg::*;
(
	input  wire logic [4:0] cur_phase,
	input  wire logic [7:0] data_byte,
	output step_res_t       res
);

	logic [1:0] st;
	logic [4:0] nx;
	logic [1:0] he_st;
	logic [4:0] he_nx;

	// Decision after the host: port, path, unsupported space or error.
	always_comb begin
		he_st = ST_MORE;
		he_nx = PH_METHOD_START;
		if (data_byte == CH_COLON) begin
			he_nx = PH_PORT;
		end else if (data_byte == CH_SLASH) begin
			he_nx = PH_PATH;
		end else begin
			he_st = (data_byte == CH_SP) ? ST_NSUP : ST_ERR;
		end
	end

	// Phase transition table.
	always_comb begin
		st = ST_MORE;
		nx = cur_phase;
		unique case (cur_phase)
			PH_METHOD_START: begin
				if (data_byte == CH_SP || data_byte == CH_HTAB ||
					data_byte == CH_CR || data_byte == CH_LF) nx = PH_METHOD_START;
				else if (is_token(data_byte)) nx = PH_METHOD;
				else st = ST_ERR;
			end
			PH_METHOD: begin
				if (is_token(data_byte)) nx = PH_METHOD;
				else if (data_byte == CH_SP) nx = PH_URI_START;
				else st = ST_ERR;
			end
			PH_URI_START: begin
				if (data_byte == CH_SP) nx = PH_URI_START;
				else if (data_byte == CH_SLASH) nx = PH_PATH;
				else if (is_alpha(data_byte)) nx = PH_SCHEME;
				else st = ST_ERR;
			end
			PH_SCHEME: begin
				if (is_scheme(data_byte)) nx = PH_SCHEME;
				else if (data_byte == CH_COLON) nx = PH_SLASH1;
				else st = ST_ERR;
			end
			PH_SLASH1: begin
				if (data_byte == CH_SLASH) nx = PH_SLASH2;
				else st = ST_ERR;
			end
			PH_SLASH2: begin
				if (data_byte == CH_SLASH) nx = PH_HOST_START;
				else st = ST_ERR;
			end
			PH_HOST_START: begin
				if (data_byte == CH_LBRK) nx = PH_IP_LITERAL;
				else if (is_host(data_byte)) nx = PH_HOST;
				else begin
					nx = he_nx;
					st = he_st;
				end
			end
			PH_HOST: begin
				if (is_host(data_byte)) nx = PH_HOST;
				else begin
					nx = he_nx;
					st = he_st;
				end
			end
			PH_HOST_END: begin
				nx = he_nx;
				st = he_st;
			end
			PH_IP_LITERAL, PH_QUERY: begin
				st = ST_NSUP;
			end
			PH_PORT: begin
				if (is_digit(data_byte)) nx = PH_PORT;
				else if (data_byte == CH_SLASH) nx = PH_PATH;
				else st = (data_byte == CH_SP) ? ST_NSUP : ST_ERR;
			end
			PH_PATH: begin
				if (data_byte == CH_SP) nx = PH_H;
				else if (data_byte == CH_QUEST) nx = PH_QUERY;
				else if (is_path(data_byte)) nx = PH_PATH;
				else st = ST_ERR;
			end
			PH_H: begin
				if (data_byte == CH_H) nx = PH_HT;
				else st = ST_ERR;
			end
			PH_HT: begin
				if (data_byte == CH_T) nx = PH_HTT;
				else st = ST_ERR;
			end
			PH_HTT: begin
				if (data_byte == CH_T) nx = PH_HTTP;
				else st = ST_ERR;
			end
			PH_HTTP: begin
				if (data_byte == CH_P) nx = PH_VSLASH;
				else st = ST_ERR;
			end
			PH_VSLASH: begin
				if (data_byte == CH_SLASH) nx = PH_MAJOR_START;
				else st = ST_ERR;
			end
			PH_MAJOR_START: begin
				if (is_digit(data_byte)) nx = PH_MAJOR;
				else st = ST_ERR;
			end
			PH_MAJOR: begin
				if (is_digit(data_byte)) nx = PH_MAJOR;
				else if (data_byte == CH_DOT) nx = PH_MINOR_START;
				else st = ST_ERR;
			end
			PH_MINOR_START: begin
				if (is_digit(data_byte)) nx = PH_MINOR;
				else st = ST_ERR;
			end
			PH_MINOR: begin
				if (is_digit(data_byte)) nx = PH_MINOR;
				else if (data_byte == CH_CR) nx = PH_LF_EXPECT;
				else if (data_byte == CH_SP) nx = PH_TRAIL_SP;
				else if (data_byte == CH_LF) st = ST_DONE;
				else st = ST_ERR;
			end
			PH_TRAIL_SP: begin
				if (data_byte == CH_SP) nx = PH_TRAIL_SP;
				else if (data_byte == CH_CR) nx = PH_LF_EXPECT;
				else if (data_byte == CH_LF) st = ST_DONE;
				else st = ST_ERR;
			end
			PH_LF_EXPECT: begin
				st = (data_byte == CH_LF) ? ST_DONE : ST_ERR;
			end
			default: begin
				st = ST_ERR;
			end
		endcase
	end

	// Any final status sends the parser back to method start.
	assign res = '{status: st, phase: (st != ST_MORE) ? PH_METHOD_START : nx};

endmodule

`default_nettype wire

@@ sv/http_request_line_checker.sv @@
// Top level of the HTTP request line checker: input register, step logic, result register.
//
// Usage:
//   Input channel: data_valid, data_stall (driven here), data_byte. One raw byte of
//   the request line is taken per request.
//   Result channel: result_valid, result_stall (driven by the receiver), status and
//   phase. Every byte gives exactly one result, in byte order.
//   Path: an accepted byte is held in the input register, the step logic works on it
//   combinationally, and its result is captured in the result register and shown there.
//   Throughput: one byte per cycle while the receiver does not stall. The phase register
//   is updated at the edge where a byte moves from the input register into the result
//   register, so the next byte sees it in the following cycle.
//   Stall: while the result register holds an untaken result and the receiver stalls,
//   the input register holds one more byte; once both are full data_stall rises.
//   Reset: arst_n clears both valid flags and sets the phase to method start.
//   After a line done, a syntax error or a not-supported case the phase is method
//   start again, so the next line may follow at once.
`default_nettype none

module http_request_line_checker
	import hrlc_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       data_valid,
	output logic            data_stall,
	input  wire logic [7:0] data_byte,
	output logic            result_valid,
	input  wire logic       result_stall,
	output logic [1:0]      status,
	output logic [4:0]      phase
);

	logic       byte_v_s1;
	logic [7:0] byte_s1;
	logic       res_v_s2;
	step_res_t  res_s2;
	logic [4:0] phase_q;
	step_res_t  step_res;
	logic       out_free;
	logic       s1_move;
	logic       in_take;

	// Handshake control.
	assign out_free   = !res_v_s2 || !result_stall;
	assign s1_move    = byte_v_s1 && out_free;
	assign data_stall = byte_v_s1 && !out_free;
	assign in_take    = data_valid && !data_stall;

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_v_s1 <= 1'b0;
		end else if (in_take) begin
			byte_v_s1 <= 1'b1;
		end else if (s1_move) begin
			byte_v_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			byte_s1 <= data_byte;
		end
	end

	// Parser step on the registered byte.
	hrlc_step u_step (
		.cur_phase (phase_q),
		.data_byte (byte_s1),
		.res       (step_res)
	);

	// Phase register follows each byte that leaves the input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_METHOD_START;
		end else if (s1_move) begin
			phase_q <= step_res.phase;
		end
	end

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_v_s2 <= 1'b0;
		end else if (out_free) begin
			res_v_s2 <= s1_move;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_move) begin
			res_s2 <= step_res;
		end
	end

	assign result_valid = res_v_s2;
	assign status       = res_s2.status;
	assign phase        = res_s2.phase;

	// A final status always comes with the method-start phase.
	a_final_phase: assert property (@(posedge clk) disable iff (!arst_n)
		(res_v_s2 && res_s2.status != ST_MORE) |-> (res_s2.phase == PH_METHOD_START))
		else $error("final status without method-start phase");

	// The phase register never holds a code beyond the last phase.
	a_phase_range: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q <= PH_LF_EXPECT)
		else $error("phase register out of range");

	// The input side stalls only when a byte is waiting in the input register and the result register is full.
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		data_stall |-> (byte_v_s1 && res_v_s2))
		else $error("input stalled without a full pipeline");

	// The phase register and the shown result agree after each transfer.
	a_phase_track: assert property (@(posedge clk) disable iff (!arst_n)
		s1_move |=> (res_v_s2 && phase_q == res_s2.phase))
		else $error("phase register does not match result");

endmodule

`default_nettype wire
